// ----- rtl/gamepad_report_conditioner_unit_assert.svh -----
// assertion macros for the gamepad report conditioner
`ifndef GAMEPAD_REPORT_CONDITIONER_UNIT_ASSERT_SVH
`define GAMEPAD_REPORT_CONDITIONER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define GRC_ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define GRC_ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition");
`else
`define GRC_ASSERT_IMPL(label, clk, rstn, prop)
`define GRC_ASSERT_NEVER(label, clk, rstn, expr)
`endif
`endif

// ----- rtl/grc_pkg.sv -----
// ----------------------------------------------------------------------------
// grc_pkg
// shared widths, constants and types of the gamepad report conditioner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package grc_pkg;
    localparam int BUTTON_COUNT = 16;
    localparam logic [15:0] BUTTON_USED = 16'((32'd1 << BUTTON_COUNT) - 32'd1);
    localparam logic [15:0] INNER_RESET = 16'd7849;
    localparam logic [15:0] OUTER_RESET = 16'd30000;
    localparam logic [0:0] CFG_INNER = 1'b0;
    localparam logic [0:0] CFG_OUTER = 1'b1;
    localparam int LEN_W = 22;   // length in 1/16 units, up to ~741k
    localparam int SUM_W = 40;   // (x*x + y*y) << 8
    localparam int T_W = 16;     // t in 0..32768 needs 16 bits plus one
    localparam int NUM_W = 36;   // 16-bit mag * 16 * t

    typedef struct packed {
        logic        start;
        logic [15:0] inner;
        logic [15:0] outer;
    } lane_ctl_t;

    // raw * 32768 = raw * 128 * 255 + raw * 128, so only the small rest is divided
    // by 255, done as (y + (y >> 8) + 1) >> 8, exact for y below 65535
    function automatic logic [15:0] trigger_level(input logic [7:0] raw);
        logic [15:0] base;
        logic [15:0] y;
        logic [15:0] s;
        base = {1'b0, raw, 7'd0};
        y = base + 16'd127;
        s = y + (y >> 8) + 16'd1;
        return base + (s >> 8);
    endfunction
endpackage
`default_nettype wire

// ----- rtl/grc_div.sv -----
// ----------------------------------------------------------------------------
// grc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module grc_div import grc_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [LEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quo
);
    logic [NUM_W-1:0] q_reg, q_next, q_step;
    logic [LEN_W:0]   r_reg, r_next, r_step;
    logic [LEN_W-1:0] d_reg;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [LEN_W:0]   trial;
    logic [LEN_W+1:0] sh;

    always_comb begin
        sh = {r_reg, q_reg[NUM_W-1]};
        trial = (LEN_W+1)'(sh - {2'b0, d_reg});
        if (sh >= {2'b0, d_reg}) begin
            r_step = trial;
            q_step = {q_reg[NUM_W-2:0], 1'b1};
        end else begin
            r_step = sh[LEN_W:0];
            q_step = {q_reg[NUM_W-2:0], 1'b0};
        end
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            q_next = num;
            r_next = '0;
            cnt_next = 6'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            r_next = r_step;
            q_next = q_step;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        if (start) d_reg <= den;
    end
    assign done = busy_reg && cnt_reg == 6'd1;
    assign quo = q_step;
endmodule
`default_nettype wire

// ----- rtl/grc_stick_lane.sv -----
// ----------------------------------------------------------------------------
// grc_stick_lane
// one stick: square root, dead zone map, rescale of both components
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module grc_stick_lane import grc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire lane_ctl_t          ctl,
    input  wire logic signed [15:0] sx,
    input  wire logic signed [15:0] sy,
    output logic                    done,
    output logic signed [15:0]      ox,
    output logic signed [15:0]      oy
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_SQ = 7'b0000010, S_SQRT = 7'b0000100,
        S_MAP = 7'b0001000, S_DT = 7'b0010000, S_DX = 7'b0100000,
        S_DY = 7'b1000000
    } st_t;
    st_t st_reg, st_next;

    logic signed [15:0] x_reg, y_reg;
    logic [15:0]        in_reg, out_reg;
    logic [SUM_W-1:0]   v_reg, v_next, res_reg, res_next, bit_reg, bit_next;
    logic [LEN_W-1:0]   len_reg;
    logic [T_W:0]       t_reg, t_next;
    logic [15:0]        ox_reg, oy_reg;
    logic [31:0]        xx, yy;
    logic [SUM_W-1:0]   cand;
    logic [LEN_W-1:0]   lo, hi;
    logic               dstart;
    logic [NUM_W-1:0]   dnum, dq;
    logic [LEN_W-1:0]   dden;
    logic               ddone;
    logic [15:0]        mag;
    logic               dvalid_x;
    logic [15:0]        sat;

    grc_div u_div (.aclk(aclk), .aresetn(aresetn), .start(dstart), .num(dnum),
        .den(dden), .done(ddone), .quo(dq));

    assign lo = LEN_W'({in_reg, 4'd0});
    assign hi = LEN_W'({out_reg, 4'd0});
    assign xx = 32'($signed(x_reg) * $signed(x_reg));
    assign yy = 32'($signed(y_reg) * $signed(y_reg));
    assign cand = res_reg + bit_reg;
    assign sat = (dq > NUM_W'(32767)) ? 16'd32767 : dq[15:0];

    function automatic logic [15:0] absv(input logic signed [15:0] c);
        return c[15] ? 16'(-c) : c;
    endfunction

    // magnitude of -32768 is kept as 32768; the quotient saturates afterwards
    always_comb begin
        st_next = st_reg;
        v_next = v_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        t_next = t_reg;
        dstart = 1'b0;
        dnum = '0;
        dden = len_reg;
        mag = '0;
        dvalid_x = 1'b0;
        unique case (st_reg)
            S_IDLE: if (ctl.start) st_next = S_SQ;
            S_SQ: begin
                v_next = SUM_W'({8'd0, 33'(xx) + 33'(yy)} << 8);
                res_next = '0;
                bit_next = SUM_W'(1) << (SUM_W - 2);
                st_next = S_SQRT;
            end
            S_SQRT: begin
                if (bit_reg == '0) st_next = S_MAP;
                else begin
                    if (v_reg >= cand) begin
                        v_next = v_reg - cand;
                        res_next = (res_reg >> 1) + bit_reg;
                    end else res_next = res_reg >> 1;
                    bit_next = bit_reg >> 2;
                end
            end
            S_MAP: begin
                if (hi <= lo) begin
                    t_next = (len_reg > lo) ? (T_W+1)'(32768) : '0;
                    st_next = S_DX;
                end else if (len_reg <= lo) begin
                    t_next = '0;
                    st_next = S_DX;
                end else if (len_reg >= hi) begin
                    t_next = (T_W+1)'(32768);
                    st_next = S_DX;
                end else begin
                    dstart = 1'b1;
                    dnum = NUM_W'({(len_reg - lo), 15'd0}) + NUM_W'((hi - lo) >> 1);
                    dden = hi - lo;
                    st_next = S_DT;
                end
                if (st_next == S_DX && !(t_next == '0 || len_reg == '0)) begin
                    dstart = 1'b1;
                    mag = absv(x_reg);
                    dnum = NUM_W'({mag, 4'd0}) * NUM_W'(t_next)
                        + NUM_W'(len_reg >> 1);
                end
            end
            S_DT: if (ddone) begin
                t_next = dq[T_W:0];
                st_next = S_DX;
                if (!(dq == '0 || len_reg == '0)) begin
                    dstart = 1'b1;
                    mag = absv(x_reg);
                    dnum = NUM_W'({mag, 4'd0}) * NUM_W'(dq[T_W:0])
                        + NUM_W'(len_reg >> 1);
                end
            end
            S_DX: begin
                if (t_reg == '0 || len_reg == '0) st_next = S_IDLE;
                else if (ddone) begin
                    dvalid_x = 1'b1;
                    dstart = 1'b1;
                    mag = absv(y_reg);
                    dnum = NUM_W'({mag, 4'd0}) * NUM_W'(t_reg) + NUM_W'(len_reg >> 1);
                    st_next = S_DY;
                end
            end
            S_DY: if (ddone) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= S_IDLE;
        else st_reg <= st_next;
        if (ctl.start) begin
            x_reg <= sx;
            y_reg <= sy;
            in_reg <= ctl.inner;
            out_reg <= ctl.outer;
        end
        v_reg <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        t_reg <= t_next;
        if (st_reg == S_SQRT && bit_reg == '0) len_reg <= LEN_W'(res_reg);
        if (st_reg == S_MAP || st_reg == S_DT) begin
            ox_reg <= '0;
            oy_reg <= '0;
        end
        if (dvalid_x) ox_reg <= x_reg[15] ? 16'(-sat) : sat;
        if (st_reg == S_DY && ddone) oy_reg <= y_reg[15] ? 16'(-sat) : sat;
    end

    assign done = (st_reg == S_DX && (t_reg == '0 || len_reg == '0))
        || (st_reg == S_DY && ddone);
    assign ox = ox_reg;
    assign oy = (st_reg == S_DY && ddone) ? (y_reg[15] ? 16'(-sat) : sat) : oy_reg;
endmodule
`default_nettype wire

// ----- rtl/gamepad_report_conditioner_unit.sv -----
// ----------------------------------------------------------------------------
// gamepad_report_conditioner_unit
// radial dead zone, trigger scaling and button edge detection per report
// ----------------------------------------------------------------------------
// channel | prefix | content
// input   | s_     | one report: buttons, triggers, two sticks
// result  | m_     | held/pressed/released masks, levels, conditioned sticks
// config  | cfg_   | index 0 inner dead zone, index 1 outer dead zone
// one report at a time: the next input transaction is taken only after the result
// is taken; square root first, then the divider up to three times per lane
// (dead-zone fraction, x, y); the fraction one is skipped outside the ramp, all at zero
// both sticks run in their own lane at the same time, a merge stage collects
// reset: synchronous active-low aresetn, dead zones 7849 / 30000, buttons up
// the result register holds while m_ready is low; no new report until taken
`timescale 1ns / 1ps
`default_nettype none
`include "gamepad_report_conditioner_unit_assert.svh"
module gamepad_report_conditioner_unit import grc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [15:0]        s_button_mask,
    input  wire logic [7:0]         s_trigger_left_raw,
    input  wire logic [7:0]         s_trigger_right_raw,
    input  wire logic signed [15:0] s_left_stick_x,
    input  wire logic signed [15:0] s_left_stick_y,
    input  wire logic signed [15:0] s_right_stick_x,
    input  wire logic signed [15:0] s_right_stick_y,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [15:0]             m_buttons_held,
    output logic [15:0]             m_pressed_now,
    output logic [15:0]             m_released_now,
    output logic [15:0]             m_trigger_left_level,
    output logic [15:0]             m_trigger_right_level,
    output logic signed [15:0]      m_left_out_x,
    output logic signed [15:0]      m_left_out_y,
    output logic signed [15:0]      m_right_out_x,
    output logic signed [15:0]      m_right_out_y
);
    // control state
    logic        busy_reg, m_valid_reg;
    logic        ldone_reg, rdone_reg;
    logic [15:0] inner_reg, outer_reg, held_reg;
    lane_ctl_t   ctl;
    logic        accept, ldone, rdone;
    logic signed [15:0] lx, ly, rx, ry;
    logic [15:0] now;

    assign s_ready = !busy_reg && !m_valid_reg;
    assign accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign now = s_button_mask & BUTTON_USED;

    assign ctl.start = accept;
    assign ctl.inner = inner_reg;
    assign ctl.outer = outer_reg;

    grc_stick_lane u_left (.aclk(aclk), .aresetn(aresetn), .ctl(ctl),
        .sx(s_left_stick_x), .sy(s_left_stick_y), .done(ldone), .ox(lx), .oy(ly));
    grc_stick_lane u_right (.aclk(aclk), .aresetn(aresetn), .ctl(ctl),
        .sx(s_right_stick_x), .sy(s_right_stick_y), .done(rdone), .ox(rx), .oy(ry));

    // merge stage: lanes finish at different times, capture each
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            ldone_reg <= 1'b0;
            rdone_reg <= 1'b0;
            inner_reg <= INNER_RESET;
            outer_reg <= OUTER_RESET;
            held_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_INNER: inner_reg <= cfg_data;
                    CFG_OUTER: outer_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                busy_reg <= 1'b1;
                ldone_reg <= 1'b0;
                rdone_reg <= 1'b0;
                held_reg <= now;
            end else if (busy_reg) begin
                if (ldone) ldone_reg <= 1'b1;
                if (rdone) rdone_reg <= 1'b1;
                if ((ldone || ldone_reg) && (rdone || rdone_reg)) begin
                    busy_reg <= 1'b0;
                    m_valid_reg <= 1'b1;
                end
            end
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
        end
        if (accept) begin
            m_buttons_held <= now;
            m_pressed_now <= now & ~held_reg;
            m_released_now <= held_reg & ~now;
            m_trigger_left_level <= trigger_level(s_trigger_left_raw);
            m_trigger_right_level <= trigger_level(s_trigger_right_raw);
        end
        if (busy_reg && ldone) begin
            m_left_out_x <= lx;
            m_left_out_y <= ly;
        end
        if (busy_reg && rdone) begin
            m_right_out_x <= rx;
            m_right_out_y <= ry;
        end
    end
    assign m_valid = m_valid_reg;

    `GRC_ASSERT_NEVER(a_no_accept_busy, aclk, aresetn, accept && (busy_reg || m_valid_reg))
    `GRC_ASSERT_NEVER(a_valid_while_busy, aclk, aresetn, busy_reg && m_valid_reg)
    `GRC_ASSERT_IMPL(a_start_busy, aclk, aresetn, accept |=> busy_reg)
endmodule
`default_nettype wire

// ----- tb/gamepad_report_conditioner_unit_test.sv -----
// ----------------------------------------------------------------------------
// gamepad_report_conditioner_unit_test
// checks button edges, trigger scaling and radial dead zone of each report
// against an in-bench predictor, over several dead-zone settings, with
// random sender bursts and receiver stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
    logic [15:0] held;
    logic [15:0] pressed;
    logic [15:0] released;
    logic [15:0] trig_l;
    logic [15:0] trig_r;
    logic [15:0] lx;
    logic [15:0] ly;
    logic [15:0] rx;
    logic [15:0] ry;
} report_result_t;

class report_scoreboard;
    logic [15:0] inner_zone;
    logic [15:0] outer_zone;
    logic [15:0] held_state;
    report_result_t pending[$];
    int errors;

    function new();
        inner_zone = grc_pkg::INNER_RESET;
        outer_zone = grc_pkg::OUTER_RESET;
        held_state = '0;
        errors = 0;
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] trig_fraction(logic [7:0] raw);
        logic [31:0] p;
        p = (32'(raw) * 32768 + 127) / 255;
        return p[15:0];
    endfunction

    function automatic logic [15:0] scale_axis(logic signed [15:0] c, logic [63:0] t,
                                               logic [63:0] len);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (c < 0) ? 64'(-32'(c)) : 64'(c);
        q = (mag * 16 * t + len / 2) / len;
        if (q > 32767) q = 32767;
        return (c < 0) ? 16'(-q) : q[15:0];
    endfunction

    function automatic void shape_stick(logic signed [15:0] x, logic signed [15:0] y,
                                        output logic [15:0] ox, output logic [15:0] oy);
        logic [63:0] sq;
        logic [63:0] len;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] t;
        sq = 64'(32'(x) * 32'(x)) + 64'(32'(y) * 32'(y));
        len = root_floor(sq << 8);
        lo = 16 * 64'(inner_zone);
        hi = 16 * 64'(outer_zone);
        if (hi <= lo) t = (len > lo) ? 32768 : 0;
        else if (len <= lo) t = 0;
        else if (len >= hi) t = 32768;
        else t = ((len - lo) * 32768 + (hi - lo) / 2) / (hi - lo);
        if (t == 0 || len == 0) begin
            ox = 0;
            oy = 0;
        end else begin
            ox = scale_axis(x, t, len);
            oy = scale_axis(y, t, len);
        end
    endfunction

    function void note_report(logic [15:0] mask, logic [7:0] tl, logic [7:0] tr,
                              logic [15:0] lx, logic [15:0] ly, logic [15:0] rx,
                              logic [15:0] ry);
        report_result_t r;
        logic [15:0] now;
        now = mask & grc_pkg::BUTTON_USED;
        r.held = now;
        r.pressed = now & ~held_state;
        r.released = held_state & ~now;
        held_state = now;
        r.trig_l = trig_fraction(tl);
        r.trig_r = trig_fraction(tr);
        shape_stick(lx, ly, r.lx, r.ly);
        shape_stick(rx, ry, r.rx, r.ry);
        pending.push_back(r);
    endfunction

    task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        errors++;
        if (errors <= 40) $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    task check_result(report_result_t got);
        report_result_t w;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 40) $display("result transaction with nothing expected");
            return;
        end
        w = pending.pop_front();
        if (got.held !== w.held) report_mismatch("buttons_held", got.held, w.held);
        if (got.pressed !== w.pressed) report_mismatch("pressed_now", got.pressed, w.pressed);
        if (got.released !== w.released)
            report_mismatch("released_now", got.released, w.released);
        if (got.trig_l !== w.trig_l) report_mismatch("trigger_left", got.trig_l, w.trig_l);
        if (got.trig_r !== w.trig_r) report_mismatch("trigger_right", got.trig_r, w.trig_r);
        if (got.lx !== w.lx) report_mismatch("left_out_x", got.lx, w.lx);
        if (got.ly !== w.ly) report_mismatch("left_out_y", got.ly, w.ly);
        if (got.rx !== w.rx) report_mismatch("right_out_x", got.rx, w.rx);
        if (got.ry !== w.ry) report_mismatch("right_out_y", got.ry, w.ry);
    endtask
endclass

module gamepad_report_conditioner_unit_test;
    import grc_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [15:0] s_button_mask = '0;
    logic [7:0] s_trigger_left_raw = '0;
    logic [7:0] s_trigger_right_raw = '0;
    logic signed [15:0] s_left_stick_x = '0;
    logic signed [15:0] s_left_stick_y = '0;
    logic signed [15:0] s_right_stick_x = '0;
    logic signed [15:0] s_right_stick_y = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [0:0] cfg_index = CFG_INNER;
    logic [15:0] cfg_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [15:0] m_buttons_held, m_pressed_now, m_released_now;
    logic [15:0] m_trigger_left_level, m_trigger_right_level;
    logic signed [15:0] m_left_out_x, m_left_out_y, m_right_out_x, m_right_out_y;

    report_scoreboard board = new();
    // receiver stall pattern: 0 free running, 1 random, 2 long stalls
    int stall_mode = 0;

    always #2 aclk = ~aclk;

    gamepad_report_conditioner_unit uut (.*);

    // result side: check every accepted transaction, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result({m_buttons_held, m_pressed_now, m_released_now,
                                m_trigger_left_level, m_trigger_right_level,
                                m_left_out_x, m_left_out_y, m_right_out_x, m_right_out_y});
        case (stall_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= ($urandom_range(0, 2) != 0);
            end
            default: begin
                m_ready <= ($urandom_range(0, 15) == 0);
            end
        endcase
    end

    // one register write while the block is idle, then cfg_valid is dropped before returning
    task automatic write_zone(logic [0:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_INNER) board.inner_zone = val;
        else board.outer_zone = val;
        @(posedge aclk);
    endtask

    // one report transaction; the gap before it is the caller's business
    task automatic send_report(logic [15:0] mask, logic [7:0] tl, logic [7:0] tr,
                               logic [15:0] lx, logic [15:0] ly, logic [15:0] rx,
                               logic [15:0] ry);
        s_valid <= 1'b1;
        s_button_mask <= mask;
        s_trigger_left_raw <= tl;
        s_trigger_right_raw <= tr;
        s_left_stick_x <= lx;
        s_left_stick_y <= ly;
        s_right_stick_x <= rx;
        s_right_stick_y <= ry;
        do @(posedge aclk); while (!s_ready);
        board.note_report(mask, tl, tr, lx, ly, rx, ry);
    endtask

    task automatic idle_cycles(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // wait until every expected result has arrived, plus slack for the pipe
    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // stick value: often full range, else near either dead-zone edge or small
    function automatic logic [15:0] pick_axis();
        int sel;
        int mag;
        sel = $urandom_range(0, 9);
        if (sel < 4) return 16'($urandom);
        if (sel < 6) mag = int'(board.inner_zone) + $urandom_range(0, 40) - 20;
        else if (sel < 8) mag = int'(board.outer_zone) + $urandom_range(0, 40) - 20;
        else mag = $urandom_range(0, 600);
        if (mag > 32767) mag = 32767;
        if (mag < 0) mag = 0;
        return ($urandom_range(0, 1) != 0) ? 16'(-mag) : 16'(mag);
    endfunction

    task automatic random_phase(int n);
        int left;
        int burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0) begin
                send_report(16'($urandom), 8'($urandom), 8'($urandom),
                            pick_axis(), pick_axis(), pick_axis(), pick_axis());
                burst--;
                left--;
            end
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 150));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset dead zones, extremes of every field
        send_report(16'hFFFF, 8'd255, 8'd0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
        send_report(16'h0000, 8'd0, 8'd255, 16'h8000, 16'h0000, 16'h0000, 16'h7FFF);
        send_report(16'hA5A5, 8'd1, 8'd128, 16'd0, 16'd0, 16'd1, 16'hFFFF);
        send_report(16'h5A5A, 8'd127, 8'd254, 16'd7849, 16'd0, 16'd7850, 16'd0);
        send_report(16'h5A5B, 8'd64, 8'd192, 16'd30000, 16'd0, 16'(-30000), 16'd0);
        send_report(16'h0001, 8'd2, 8'd3, 16'd18000, 16'(-12000), 16'(-5), 16'd20000);
        // disconnected pad
        send_report(16'h0000, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        drain();

        // hard step: outer not above inner
        write_zone(CFG_INNER, 16'd1000);
        write_zone(CFG_OUTER, 16'd1000);
        send_report(16'h8000, 8'd10, 8'd20, 16'd1000, 16'd0, 16'd1001, 16'd0);
        send_report(16'h0000, 8'd30, 8'd40, 16'd600, 16'd800, 16'(-706), 16'(-708));
        drain();

        // no dead zone at all, then widest extremes
        write_zone(CFG_INNER, 16'd0);
        write_zone(CFG_OUTER, 16'd1);
        send_report(16'h00FF, 8'd255, 8'd255, 16'd1, 16'd0, 16'd0, 16'(-1));
        send_report(16'hFF00, 8'd0, 8'd0, 16'h8000, 16'h7FFF, 16'd3, 16'd4);
        drain();
        write_zone(CFG_INNER, 16'd46341);
        write_zone(CFG_OUTER, 16'd46341);
        send_report(16'hFFFF, 8'd9, 8'd99, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
        drain();
        write_zone(CFG_INNER, 16'd0);
        write_zone(CFG_OUTER, 16'd46341);
        send_report(16'h1234, 8'd50, 8'd200, 16'h8000, 16'h8000, 16'h7FFF, 16'h1000);
        drain();

        // random phases over several settings and stall patterns
        for (int ph = 0; ph < 8; ph++) begin
            stall_mode = ph % 3;
            case (ph)
                0: begin
                    write_zone(CFG_INNER, INNER_RESET);
                    write_zone(CFG_OUTER, OUTER_RESET);
                end
                1: begin
                    write_zone(CFG_INNER, 16'd0);
                    write_zone(CFG_OUTER, 16'd46341);
                end
                2: begin
                    write_zone(CFG_INNER, 16'd20000);
                    write_zone(CFG_OUTER, 16'd5000);
                end
                default: begin
                    write_zone(CFG_INNER, 16'($urandom_range(0, 20000)));
                    write_zone(CFG_OUTER, 16'($urandom_range(1, 46341)));
                end
            endcase
            random_phase(235);
            drain();
        end

        if (board.errors == 0) $display("gamepad_report_conditioner_unit verification clean");
        else $display("gamepad_report_conditioner_unit verification failed");
        $finish;
    end

    // generous time limit
    initial begin
        #20ms;
        $display("gamepad_report_conditioner_unit verification failed");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/grc_pkg.sv
rtl/grc_div.sv
rtl/grc_stick_lane.sv
rtl/gamepad_report_conditioner_unit.sv
tb/gamepad_report_conditioner_unit_test.sv
